FILE: design/lbp_3x3_code_stream_assert.svh
// Assertion macros used by the checker of the LBP code stream block.
`ifndef LBP_3X3_CODE_STREAM_ASSERT_SVH
`define LBP_3X3_CODE_STREAM_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LBP3_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LBP3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lbp3_pkg.sv
// Types and constants shared by the LBP code stream block and its checker.
package lbp3_pkg;

  localparam int PIXEL_W      = 8;
  localparam int CODE_W       = 8;
  localparam int IMG_WIDTH_W  = 12;
  localparam int IMG_HEIGHT_W = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RESET  = 12'd640;
  localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RESET = 16'd480;
  localparam int MIN_DIM = 3;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [CODE_W-1:0]  code_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

endpackage

FILE: design/lbp3_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lbp3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lbp_3x3_code_stream.sv
// Top level of the 3x3 local binary pattern encoder for a raster pixel stream.
//
// One pixel beat is taken per clock, sustained while the output is not stalled.
// The code of the pixel up and to the left of it is formed while the pixel sits
// in the input stage and leaves from the output register. The two line buffers
// are RAMs read when a pixel is accepted and written when it leaves the input
// stage. Border pixels give no output beat. The line buffers are not cleared
// after reset; a frame that begins with frame_start never uses stale entries.
// Write the image size only while no pixel is in flight.
module lbp_3x3_code_stream
  import lbp3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PIXEL_W-1:0]     in_pixel,
  input  logic                   in_frame_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CODE_W-1:0]      out_lbp_code,
  output logic                   out_row_end,
  output logic                   out_frame_end,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);

  logic [IMG_WIDTH_W-1:0]  img_width_r;
  logic [IMG_HEIGHT_W-1:0] img_height_r;
  logic [EW-1:0]           eff_width;
  logic [IMG_HEIGHT_W-1:0] eff_height;

  logic [CW-1:0]           col_cnt_r, col_cnt_nxt;
  logic [IMG_HEIGHT_W-1:0] row_cnt_r, row_cnt_nxt;

  logic [EW-1:0]           col_base, col_cur, col_inc;
  logic [IMG_HEIGHT_W-1:0] row_base, row_wrap, row_cur, row_inc;
  logic                    col_wrap, last_col, last_row, emit;
  logic [CW-1:0]           rd_addr;

  logic                    accept, s1_adv, fwd_hit;

  logic                    s1_valid_r;
  pixel_t                  s1_pixel_r;
  logic [CW-1:0]           s1_addr_r;
  logic                    s1_emit_r, s1_row_end_r, s1_frame_end_r;
  logic                    s1_fwd_r;
  pixel_t                  s1_fwd_top_r, s1_fwd_mid_r;

  pixel_t                  upper_rdata, middle_rdata;
  pixel_t                  top_px, mid_px;
  pixel_t                  win_r [6];
  code_t                   code;

  logic                    out_valid_r;
  code_t                   out_code_r;
  logic                    out_row_end_r, out_frame_end_r;

  // The image size is clamped to the range the counters support.
  always_comb begin
    if (img_width_r < IMG_WIDTH_W'(MIN_DIM)) begin
      eff_width = EW'(MIN_DIM);
    end else if (32'(img_width_r) > 32'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = EW'(img_width_r);
    end
    if (img_height_r < IMG_HEIGHT_W'(MIN_DIM)) begin
      eff_height = IMG_HEIGHT_W'(MIN_DIM);
    end else begin
      eff_height = img_height_r;
    end
  end

  always_comb begin
    col_base = in_frame_start ? '0 : EW'(col_cnt_r);
    row_base = in_frame_start ? '0 : row_cnt_r;
    col_wrap = (col_base >= eff_width);
    col_cur  = col_wrap ? '0 : col_base;
    row_wrap = col_wrap ? row_base + 1'b1 : row_base;
    row_cur  = (row_wrap >= eff_height) ? '0 : row_wrap;
    col_inc  = col_cur + 1'b1;
    row_inc  = row_cur + 1'b1;
    last_col = (col_inc == eff_width);
    last_row = (row_inc == eff_height);
    emit     = (row_cur >= IMG_HEIGHT_W'(2)) && (col_cur >= EW'(2));
    rd_addr  = col_cur[CW-1:0];
    if (last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = last_row ? '0 : row_inc;
    end else begin
      col_cnt_nxt = col_inc[CW-1:0];
      row_cnt_nxt = row_cur;
    end
  end

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign accept    = in_valid && in_ready;
  assign fwd_hit   = s1_adv && (s1_addr_r == rd_addr);
  assign cfg_ready = 1'b1;

  assign top_px = s1_fwd_r ? s1_fwd_top_r : upper_rdata;
  assign mid_px = s1_fwd_r ? s1_fwd_mid_r : middle_rdata;

  lbp3_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata (mid_px),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (upper_rdata)
  );

  lbp3_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata (s1_pixel_r),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (middle_rdata)
  );

  // Window layout: entries 0..2 are top, middle, bottom of the newer column,
  // entries 3..5 the same of the older column; the centre is entry 1.
  always_comb begin
    code[7] = (win_r[3]   >= win_r[1]);
    code[6] = (win_r[0]   >= win_r[1]);
    code[5] = (top_px     >= win_r[1]);
    code[4] = (mid_px     >= win_r[1]);
    code[3] = (s1_pixel_r >= win_r[1]);
    code[2] = (win_r[2]   >= win_r[1]);
    code[1] = (win_r[5]   >= win_r[1]);
    code[0] = (win_r[4]   >= win_r[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= IMG_WIDTH_RESET;
      img_height_r <= IMG_HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:  img_width_r  <= cfg_data[IMG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: img_height_r <= cfg_data[IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt_r  <= col_cnt_nxt;
        row_cnt_r  <= row_cnt_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel_r     <= in_pixel;
      s1_addr_r      <= rd_addr;
      s1_emit_r      <= emit;
      s1_row_end_r   <= last_col;
      s1_frame_end_r <= last_col && last_row;
      s1_fwd_r       <= fwd_hit;
      s1_fwd_top_r   <= mid_px;
      s1_fwd_mid_r   <= s1_pixel_r;
    end
    if (s1_adv) begin
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= top_px;
      win_r[1] <= mid_px;
      win_r[2] <= s1_pixel_r;
      out_code_r      <= code;
      out_row_end_r   <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_emit_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lbp_code  = out_code_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

FILE: design/lbp3_checker.sv
// Port-level checker for the LBP code stream block and its bind statement.
`include "lbp_3x3_code_stream_assert.svh"

module lbp3_checker
  import lbp3_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [CODE_W-1:0]      out_lbp_code,
  input logic                   out_row_end,
  input logic                   out_frame_end
);

  `LBP3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_lbp_code) && $stable(out_row_end) && $stable(out_frame_end), "Output beat changed while stalled.")
  `LBP3_ASSERT_IMPL(a_frame_end_row_end, out_valid && out_frame_end, out_row_end, "Frame end without row end.")
  `LBP3_ASSERT_IMPL(a_out_follows_in, $rose(out_valid), $past(in_valid && in_ready, 2), "Output beat without a pixel beat two clocks earlier.")
  `LBP3_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "Input stalled while the output register is empty.")

endmodule

bind lbp_3x3_code_stream lbp3_checker u_lbp3_checker (.*);

FILE: bench/lbp_3x3_code_stream_test.sv
// Self-checking testbench for the 3x3 local binary pattern code stream block.
`timescale 1ns / 100ps

class lbp_code_board;
  localparam int LINE_DEPTH = 2048;

  typedef struct packed {
    lbp3_pkg::code_t code;
    logic            row_end;
    logic            frame_end;
  } code_beat_t;

  logic [lbp3_pkg::IMG_WIDTH_W-1:0]  width_reg;
  logic [lbp3_pkg::IMG_HEIGHT_W-1:0] height_reg;
  lbp3_pkg::pixel_t above_row [LINE_DEPTH];
  lbp3_pkg::pixel_t prev_row [LINE_DEPTH];
  lbp3_pkg::pixel_t near_col [3];
  lbp3_pkg::pixel_t far_col [3];
  int unsigned col;
  int unsigned row;
  code_beat_t pending_codes [$];
  int unsigned codes_seen;
  int unsigned row_ends_seen;
  int unsigned frame_ends_seen;
  int unsigned errors;

  function new();
    width_reg = lbp3_pkg::IMG_WIDTH_RESET;
    height_reg = lbp3_pkg::IMG_HEIGHT_RESET;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      above_row[i] = '0;
      prev_row[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      near_col[i] = '0;
      far_col[i] = '0;
    end
    col = 0;
    row = 0;
    codes_seen = 0;
    row_ends_seen = 0;
    frame_ends_seen = 0;
    errors = 0;
  endfunction

  function void note_config(lbp3_pkg::cfg_index_t idx, logic [lbp3_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      lbp3_pkg::CFG_IMAGE_WIDTH: width_reg = data[lbp3_pkg::IMG_WIDTH_W-1:0];
      lbp3_pkg::CFG_IMAGE_HEIGHT: height_reg = data[lbp3_pkg::IMG_HEIGHT_W-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned line_width();
    if (width_reg < lbp3_pkg::MIN_DIM) return lbp3_pkg::MIN_DIM;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function int unsigned frame_height();
    if (height_reg < lbp3_pkg::MIN_DIM) return lbp3_pkg::MIN_DIM;
    return height_reg;
  endfunction

  function int unsigned waiting();
    return pending_codes.size();
  endfunction

  function void note_pixel(lbp3_pkg::pixel_t px, logic first);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    lbp3_pkg::pixel_t top;
    lbp3_pkg::pixel_t mid;
    lbp3_pkg::pixel_t ctr;
    code_beat_t beat;
    w = line_width();
    h = frame_height();
    if (first) begin
      col = 0;
      row = 0;
    end
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;
    c = col;
    r = row;
    top = above_row[c];
    mid = prev_row[c];
    if (r >= 2 && c >= 2) begin
      ctr = near_col[1];
      beat.code = {far_col[0] >= ctr, near_col[0] >= ctr, top >= ctr, mid >= ctr,
                   px >= ctr, near_col[2] >= ctr, far_col[2] >= ctr, far_col[1] >= ctr};
      beat.row_end = (c + 1 == w);
      beat.frame_end = (c + 1 == w) && (r + 1 == h);
      pending_codes.push_back(beat);
    end
    above_row[c] = mid;
    prev_row[c] = px;
    far_col = near_col;
    near_col[0] = top;
    near_col[1] = mid;
    near_col[2] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col = c;
    row = r;
  endfunction

  function void check_code(lbp3_pkg::code_t code, logic row_end, logic frame_end);
    code_beat_t want;
    if (pending_codes.size() == 0) begin
      $error("Unexpected code beat: lbp_code %02h row_end %b frame_end %b",
             code, row_end, frame_end);
      errors++;
      return;
    end
    want = pending_codes.pop_front();
    codes_seen++;
    if (want.row_end) row_ends_seen++;
    if (want.frame_end) frame_ends_seen++;
    if (code !== want.code) begin
      $error("lbp_code: expected %02h, actual %02h", want.code, code);
      errors++;
    end
    if (row_end !== want.row_end) begin
      $error("row_end: expected %b, actual %b", want.row_end, row_end);
      errors++;
    end
    if (frame_end !== want.frame_end) begin
      $error("frame_end: expected %b, actual %b", want.frame_end, frame_end);
      errors++;
    end
  endfunction
endclass

module lbp_3x3_code_stream_test;
  import lbp3_pkg::*;

  localparam int RANDOM_PER_PHASE = 60;
  localparam int N_PHASES = 8;
  localparam int HOLD_PHASE = 2;
  localparam int PAUSE_PHASE = 5;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 5000;
  localparam longint RUN_LIMIT_NS = 4_000_000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [PIXEL_W-1:0]     in_pixel;
  logic                   in_frame_start;
  logic                   out_valid;
  logic                   out_ready;
  logic [CODE_W-1:0]      out_lbp_code;
  logic                   out_row_end;
  logic                   out_frame_end;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lbp_code_board board;
  bit src_idles = 1'b1;
  bit sink_stalls = 1'b1;
  bit hold_off_req = 1'b0;
  int unsigned texture_base = 128;
  int unsigned pixels_sent = 0;
  int unsigned sizes_used = 0;
  int unsigned input_stalls = 0;

  logic [CFG_DATA_W-1:0] phase_w [N_PHASES] = '{16'd5, 16'd3, 16'hF011, 16'd8,
                                                 16'd4095, 16'd6, 16'd2, 16'd11};
  logic [CFG_DATA_W-1:0] phase_h [N_PHASES] = '{16'd4, 16'd65535, 16'd6, 16'd3,
                                                 16'd3, 16'd5, 16'd1, 16'd7};
  pixel_t demo_px [27] = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd0, 8'd127, 8'd129, 8'd255,
                           8'd254, 8'd255, 8'd254, 8'd255, 8'd255, 8'd254, 8'd255, 8'd254,
                           8'd255, 8'd0, 8'd7, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3};

  lbp_3x3_code_stream dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_code(out_lbp_code, out_row_end, out_frame_end);
    if (rst_n && in_valid && !in_ready) input_stalls++;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pixel_t pick_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return pixel_t'($urandom_range(0, 255));
    if (roll == 4) return '0;
    if (roll == 5) return '1;
    return pixel_t'(texture_base + $urandom_range(0, 2) - 1);
  endfunction

  initial begin : result_sink
    int unsigned n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!sink_stalls || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        n = sink_stalls ? $urandom_range(1, 12) : 1;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        n = pick_gap();
        repeat (n == 0 ? 1 : n) @(posedge clk);
      end
    end
  end

  task automatic send_pixel(input pixel_t px, input logic first);
    int unsigned gap;
    in_valid <= 1'b1;
    in_pixel <= px;
    in_frame_start <= first;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(px, first);
    pixels_sent++;
    gap = src_idles ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (board.waiting() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.note_config(idx, data);
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    if ($urandom_range(0, 1) != 0) begin
      write_reg(CFG_IMAGE_WIDTH, w);
      write_reg(CFG_IMAGE_HEIGHT, h);
    end else begin
      write_reg(CFG_IMAGE_HEIGHT, h);
      write_reg(CFG_IMAGE_WIDTH, w);
    end
    cfg_valid <= 1'b0;
    sizes_used++;
  endtask

  task automatic send_run(input logic marked, input int unsigned count, input bit noisy);
    texture_base = $urandom_range(1, 254);
    for (int unsigned i = 0; i < count; i++) begin
      if (noisy) send_pixel(pick_pixel(), $urandom_range(0, 5) == 0);
      else send_pixel(pick_pixel(), marked && i == 0);
    end
  endtask

  initial begin : stimulus
    int unsigned budget;
    int unsigned start;
    int unsigned frame_len;
    int unsigned left;
    int unsigned kind;
    bit paused;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pixel <= '0;
    in_frame_start <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data <= '0;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_size(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) send_pixel(demo_px[i], i == 0);
    drain();
    set_size(16'd1, 16'd0);
    for (int i = 9; i < 27; i++) send_pixel(demo_px[i], i == 9);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      set_size(phase_w[p], phase_h[p]);
      if (p == HOLD_PHASE) hold_off_req = 1'b1;
      budget = RANDOM_PER_PHASE;
      start = pixels_sent;
      paused = 1'b0;
      while (pixels_sent - start < budget) begin
        left = budget - (pixels_sent - start);
        frame_len = board.line_width() * board.frame_height();
        kind = (pixels_sent == start || !src_idles) ? 0 : $urandom_range(0, 9);
        if (kind <= 6 || kind == 9) begin
          send_run(kind != 6, frame_len < left ? frame_len : left, 1'b0);
        end else if (kind == 7) begin
          frame_len = $urandom_range(1, frame_len - 1);
          send_run(1'b1, frame_len < left ? frame_len : left, 1'b0);
        end else begin
          frame_len = $urandom_range(1, 6);
          send_run(1'b0, frame_len < left ? frame_len : left, 1'b1);
        end
        if (p == PAUSE_PHASE && !paused && pixels_sent - start >= budget / 2) begin
          paused = 1'b1;
          drain();
          set_size(16'd4, 16'd3);
        end
      end
      src_idles = 1'b1;
      sink_stalls = 1'b1;
      drain();
    end

    drain();
    if (board.waiting() != 0) begin
      $error("%0d expected code beats never arrived", board.waiting());
      board.errors++;
    end
    $display("Sent %0d pixels under %0d image size settings; checked %0d codes,",
             pixels_sent, sizes_used, board.codes_seen);
    $display("%0d row ends and %0d frame ends; input held back on %0d cycles (%0d-cycle hold-off).",
             board.row_ends_seen, board.frame_ends_seen, input_stalls, HOLD_OFF_CYCLES);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
